>>> src/svptw_pkg.sv
// Package for the Sv39 page table walker: widths, entry bit positions, queue item type
// and the helper that forms a table entry address. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package svptw_pkg;

	// Field widths.
	localparam int VA_W       = 39;
	localparam int PA_W       = 56;
	localparam int ENTRY_W    = 64;
	localparam int VPN_W      = 27;
	localparam int VPN_SEG_W  = 9;
	localparam int LEVEL_W    = 2;
	localparam int PAGE_SHIFT = 12;
	localparam int PTE_SHIFT  = 3;

	// Page table entry layout.
	localparam int PTE_V_BIT   = 0;
	localparam int PTE_R_BIT   = 1;
	localparam int PTE_X_BIT   = 3;
	localparam int PPN_LSB     = 10;
	localparam int PPN_MSB     = 53;

	// Number of translation levels; the walk starts at the top one.
	localparam int LEVELS = 3;
	localparam logic [LEVEL_W-1:0] START_LEVEL = LEVEL_W'(LEVELS - 1);

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Input command codes.
	localparam logic CMD_START    = 1'b0;
	localparam logic CMD_RESPONSE = 1'b1;

	// Result kind codes.
	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_FINISH  = 1'b1;

	// Classified operation carried through the queue.
	typedef enum logic [1:0] {
		OP_START,
		OP_INVALID,
		OP_LEAF,
		OP_POINTER
	} op_t;

	// One queued word: the operation, a table base and the page numbers.
	typedef struct packed {
		op_t              op;
		logic [PA_W-1:0]  base;
		logic [VPN_W-1:0] vpn;
	} item_t;

	// Picks the 9-bit page number for a level; levels above the address give zero.
	function automatic logic [VPN_SEG_W-1:0] vpn_index(
		input logic [VPN_W-1:0]   pn,
		input logic [LEVEL_W-1:0] level
	);
		logic [VPN_SEG_W-1:0] idx;
		unique case (level)
			2'd0: idx = pn[VPN_SEG_W-1:0];
			2'd1: idx = pn[2*VPN_SEG_W-1:VPN_SEG_W];
			2'd2: idx = pn[3*VPN_SEG_W-1:2*VPN_SEG_W];
			default: idx = '0;
		endcase
		return idx;
	endfunction

	// Entry address: table base plus eight times the level's index, wrapping at 56 bits.
	function automatic logic [PA_W-1:0] entry_addr(
		input logic [PA_W-1:0]    base,
		input logic [VPN_W-1:0]   pn,
		input logic [LEVEL_W-1:0] level
	);
		logic [PA_W-1:0] offset;
		offset = PA_W'({vpn_index(pn, level), {PTE_SHIFT{1'b0}}});
		return base + offset;
	endfunction

endpackage

`default_nettype wire

>>> src/svptw_front.sv
// Front end of the page table walker: decodes each incoming word into a queue item.
// Depends on svptw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svptw_front import svptw_pkg::*; (
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               command,
	input  wire logic [VA_W-1:0]    virtual_address,
	input  wire logic [PA_W-1:0]    root_table_address,
	input  wire logic [ENTRY_W-1:0] entry_data,
	output logic                    push_valid,
	input  wire logic               push_ready,
	output item_t                   push_item
);

	logic leaf_bits;

	// Any of the read, write or execute permission bits marks a leaf.
	assign leaf_bits = |entry_data[PTE_X_BIT:PTE_R_BIT];

	// The front only stalls when the queue is full.
	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	// Classify the word and prepare the base address the back end needs.
	always_comb begin
		push_item.vpn = virtual_address[PAGE_SHIFT+VPN_W-1:PAGE_SHIFT];
		if (command == CMD_START) begin
			push_item.op   = OP_START;
			push_item.base = root_table_address;
		end else begin
			push_item.base = {entry_data[PPN_MSB:PPN_LSB], {PAGE_SHIFT{1'b0}}};
			priority if (!entry_data[PTE_V_BIT]) begin
				push_item.op = OP_INVALID;
			end else if (leaf_bits) begin
				push_item.op = OP_LEAF;
			end else begin
				push_item.op = OP_POINTER;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/svptw_queue.sv
// Short queue between the front and the back of the page table walker.
// Depends on svptw_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module svptw_queue import svptw_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire item_t push_item,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output item_t      pop_item
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Storage is written at the tail.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/svptw_back.sv
// Back end of the page table walker: walk state, entry address generation and the
// output register. Depends on svptw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svptw_back import svptw_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          pop_valid,
	output logic               pop_ready,
	input  wire item_t         pop_item,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic               result_kind,
	output logic [PA_W-1:0]    address,
	output logic               found
);

	logic               busy_q;
	logic [LEVEL_W-1:0] level_q;
	logic [VPN_W-1:0]   vpn_q;
	logic [PA_W-1:0]    pend_addr_q;
	logic               out_valid_q;
	logic               kind_q;
	logic [PA_W-1:0]    addr_q;
	logic               found_q;

	logic               busy_d;
	logic [LEVEL_W-1:0] level_d;
	logic [VPN_W-1:0]   vpn_d;
	logic [PA_W-1:0]    pend_addr_d;
	logic               emit;
	logic               kind_d;
	logic [PA_W-1:0]    addr_d;
	logic               found_d;
	logic               take;
	logic [LEVEL_W-1:0] level_dn;

	// A word is taken whenever the output register is free or being drained.
	assign pop_ready = !out_valid_q || out_ready;
	assign take      = pop_valid && pop_ready;
	assign level_dn  = level_q - 1'b1;

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign address     = addr_q;
	assign found       = found_q;

	// Walk step for the word at the head of the queue.
	always_comb begin
		busy_d      = busy_q;
		level_d     = level_q;
		vpn_d       = vpn_q;
		pend_addr_d = pend_addr_q;
		emit        = 1'b0;
		kind_d      = KIND_REQUEST;
		addr_d      = '0;
		found_d     = 1'b0;
		if (take) begin
			unique case (pop_item.op)
				OP_START: begin
					if (!busy_q) begin
						busy_d      = 1'b1;
						level_d     = START_LEVEL;
						vpn_d       = pop_item.vpn;
						pend_addr_d = entry_addr(pop_item.base, pop_item.vpn, START_LEVEL);
						emit        = 1'b1;
						addr_d      = pend_addr_d;
					end
				end
				OP_INVALID: begin
					if (busy_q) begin
						busy_d = 1'b0;
						emit   = 1'b1;
						kind_d = KIND_FINISH;
					end
				end
				OP_LEAF: begin
					if (busy_q) begin
						busy_d  = 1'b0;
						emit    = 1'b1;
						kind_d  = KIND_FINISH;
						addr_d  = pend_addr_q;
						found_d = 1'b1;
					end
				end
				OP_POINTER: begin
					if (busy_q) begin
						emit = 1'b1;
						if (level_q == '0) begin
							// Pointer at the last level: no leaf exists.
							busy_d = 1'b0;
							kind_d = KIND_FINISH;
						end else begin
							level_d     = level_dn;
							pend_addr_d = entry_addr(pop_item.base, vpn_q, level_dn);
							addr_d      = pend_addr_d;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Walk state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			level_q     <= '0;
			vpn_q       <= '0;
			pend_addr_q <= '0;
		end else begin
			busy_q      <= busy_d;
			level_q     <= level_d;
			vpn_q       <= vpn_d;
			pend_addr_q <= pend_addr_d;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= emit;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= kind_d;
			addr_q  <= addr_d;
			found_q <= found_d;
		end
	end

endmodule

`default_nettype wire

>>> src/sv39_page_table_walker_top.sv
// Sv39 page table walker, top level. An accepted input word is written into the queue;
// the back end step then takes it from the queue and loads its result word, if any,
// into the output register.
// Throughput: one input word per cycle unless out_ready stalls the output register;
// a word that causes no result still passes through the back end walk step.
// Reset: arst_n clears the queue, the output valid flag and the walk state to idle.
// Depends on svptw_pkg, svptw_front, svptw_queue and svptw_back.
`timescale 1ns / 1ps
`default_nettype none

module sv39_page_table_walker_top import svptw_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               command,
	input  wire logic [VA_W-1:0]    virtual_address,
	input  wire logic [PA_W-1:0]    root_table_address,
	input  wire logic [ENTRY_W-1:0] entry_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    result_kind,
	output logic [PA_W-1:0]         address,
	output logic                    found
);

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	// Decode incoming words.
	svptw_front u_front (
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.command            (command),
		.virtual_address    (virtual_address),
		.root_table_address (root_table_address),
		.entry_data         (entry_data),
		.push_valid         (push_valid),
		.push_ready         (push_ready),
		.push_item          (push_item)
	);

	// Decouple front and back.
	svptw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// Walk state and result register.
	svptw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_item    (pop_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.address     (address),
		.found       (found)
	);

endmodule

`default_nettype wire

>>> test/tb.sv
// Testbench for sv39_page_table_walker_top: directed table, then random walks checked
// against a cycle-free walk predictor. Depends on svptw_pkg and the walker RTL.
`timescale 1ns / 1ps

module tb;
	import svptw_pkg::*;

	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 180;
	localparam int RANDOM_WORDS = 650;

	// One output word of the walker.
	typedef struct packed {
		logic            kind;
		logic [PA_W-1:0] addr;
		logic            found;
	} walk_word_t;

	// One row of the directed table; typed rows carry their own expectation.
	typedef struct {
		logic               cmd;
		logic [VA_W-1:0]    va;
		logic [PA_W-1:0]    root;
		logic [ENTRY_W-1:0] pte;
		bit                 typed;
		bit                 has;
		walk_word_t         res;
	} stim_row_t;

	typedef enum int {
		PTE_INVALID,
		PTE_LEAF,
		PTE_POINTER
	} pte_class_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               command;
	logic [VA_W-1:0]    virtual_address;
	logic [PA_W-1:0]    root_table_address;
	logic [ENTRY_W-1:0] entry_data;
	logic               out_valid;
	logic               out_ready;
	logic               result_kind;
	logic [PA_W-1:0]    address;
	logic               found;

	// Predicted walker state.
	bit                 walker_busy;
	logic [LEVEL_W-1:0] walker_level;
	logic [VPN_W-1:0]   walker_vpn;
	logic [PA_W-1:0]    walker_entry_addr;

	walk_word_t expected_walk_words[$];
	stim_row_t  directed_rows[$];
	int         fail_count;
	int         mismatch_count;
	int         results_seen;
	int         burst_left;
	int         hold_left;
	int         idle_cycles;

	sv39_page_table_walker_top u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.command            (command),
		.virtual_address    (virtual_address),
		.root_table_address (root_table_address),
		.entry_data         (entry_data),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.result_kind        (result_kind),
		.address            (address),
		.found              (found)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Address of the entry for a level: table base plus eight times its page number.
	function automatic logic [PA_W-1:0] table_slot(input logic [PA_W-1:0] base,
			input logic [VPN_W-1:0] vpn, input logic [LEVEL_W-1:0] level);
		logic [VPN_SEG_W-1:0] idx;
		case (level)
			2'd0: idx = vpn[8:0];
			2'd1: idx = vpn[17:9];
			2'd2: idx = vpn[26:18];
			default: idx = '0;
		endcase
		return base + {{(PA_W-VPN_SEG_W-3){1'b0}}, idx, 3'b000};
	endfunction

	// Advances the predicted walk by one accepted word.
	task automatic walk_step(input logic cmd, input logic [VA_W-1:0] va,
			input logic [PA_W-1:0] root, input logic [ENTRY_W-1:0] pte,
			output bit has, output walk_word_t r);
		logic [PA_W-1:0] next_base;
		has = 1'b0;
		r = '0;
		if (cmd == CMD_START) begin
			if (!walker_busy) begin
				walker_busy = 1'b1;
				walker_level = LEVEL_W'(LEVELS - 1);
				walker_vpn = va[VA_W-1:PAGE_SHIFT];
				walker_entry_addr = table_slot(root, walker_vpn, walker_level);
				has = 1'b1;
				r.kind = KIND_REQUEST;
				r.addr = walker_entry_addr;
			end
		end else if (walker_busy) begin
			has = 1'b1;
			r.kind = KIND_FINISH;
			if (!pte[PTE_V_BIT]) begin
				walker_busy = 1'b0;
			end else if (|pte[PTE_X_BIT:PTE_R_BIT]) begin
				walker_busy = 1'b0;
				r.addr = walker_entry_addr;
				r.found = 1'b1;
			end else if (walker_level == 0) begin
				walker_busy = 1'b0;
			end else begin
				next_base = {pte[PPN_MSB:PPN_LSB], {PAGE_SHIFT{1'b0}}};
				walker_level = walker_level - 1'b1;
				walker_entry_addr = table_slot(next_base, walker_vpn, walker_level);
				r.kind = KIND_REQUEST;
				r.addr = walker_entry_addr;
			end
		end
	endtask

	// Offers one input word in bursts with random gaps and records its expectation.
	task automatic send_word(input logic cmd, input logic [VA_W-1:0] va,
			input logic [PA_W-1:0] root, input logic [ENTRY_W-1:0] pte,
			input bit typed, input bit typed_has, input walk_word_t typed_res,
			output bit had);
		int         gap;
		bit         has;
		walk_word_t r;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 10);
		end
		burst_left--;
		in_valid <= 1'b1;
		command <= cmd;
		virtual_address <= va;
		root_table_address <= root;
		entry_data <= pte;
		do @(posedge clk); while (!in_ready);
		walk_step(cmd, va, root, pte, has, r);
		if (typed) begin
			has = typed_has;
			r = typed_res;
		end
		if (has)
			expected_walk_words.push_back(r);
		had = has;
	endtask

	// Random word checked against the predictor; counts every word offered.
	task automatic offer(input logic cmd, input logic [VA_W-1:0] va,
			input logic [PA_W-1:0] root, input logic [ENTRY_W-1:0] pte, inout int produced);
		bit had;
		send_word(cmd, va, root, pte, 1'b0, 1'b0, '0, had);
		produced++;
	endtask

	// Random page table entry of the requested class.
	function automatic logic [ENTRY_W-1:0] make_entry(input pte_class_t cls);
		logic [ENTRY_W-1:0] e;
		e = {$urandom(), $urandom()};
		case (cls)
			PTE_INVALID: e[PTE_V_BIT] = 1'b0;
			PTE_LEAF: begin
				e[PTE_V_BIT] = 1'b1;
				e[PTE_X_BIT:PTE_R_BIT] = 3'($urandom_range(1, 7));
			end
			default: begin
				e[PTE_V_BIT] = 1'b1;
				e[PTE_X_BIT:PTE_R_BIT] = 3'b000;
			end
		endcase
		return e;
	endfunction

	task automatic add_row(input logic cmd, input logic [VA_W-1:0] va,
			input logic [PA_W-1:0] root, input logic [ENTRY_W-1:0] pte,
			input bit typed, input bit has, input logic kind,
			input logic [PA_W-1:0] addr, input logic fnd);
		stim_row_t row;
		row.cmd = cmd;
		row.va = va;
		row.root = root;
		row.pte = pte;
		row.typed = typed;
		row.has = has;
		row.res.kind = kind;
		row.res.addr = addr;
		row.res.found = fnd;
		directed_rows.push_back(row);
	endtask

	// Output checker: every accepted word is compared with the oldest expectation.
	always @(posedge clk) begin
		walk_word_t got;
		walk_word_t want;
		if (arst_n && out_valid && out_ready) begin
			got.kind = result_kind;
			got.addr = address;
			got.found = found;
			results_seen++;
			if (expected_walk_words.size() == 0) begin
				fail_count++;
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected word: kind %0d addr %h found %0d",
						got.kind, got.addr, got.found);
			end else begin
				want = expected_walk_words.pop_front();
				if (got !== want) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected kind %0d addr %h found %0d, got kind %0d addr %h found %0d",
							want.kind, want.addr, want.found, got.kind, got.addr, got.found);
				end
			end
		end
	end

	// Receiver: stall pattern drawn at random from four modes, plus two long hold-offs.
	initial begin
		int   cyc;
		int   mode;
		bit   hold_a_done;
		bit   hold_b_done;
		cyc = 0;
		mode = 0;
		hold_a_done = 1'b0;
		hold_b_done = 1'b0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 50 == 0)
				mode = $urandom_range(0, 3);
			if (!hold_a_done && results_seen >= 80) begin
				hold_a_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (!hold_b_done && results_seen >= 400) begin
				hold_b_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 0);
					2: out_ready <= (cyc % 4 == 0);
					default: out_ready <= ($urandom_range(0, 99) < 85);
				endcase
			end
		end
	end

	// Watchdog on cycles with work outstanding but no word moving.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else if (in_valid || expected_walk_words.size() != 0) begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("** sv39_page_table_walker_top: FAILED **");
				$finish;
			end
		end
	end

	// Main sequence: reset, directed table, random walks, drain.
	initial begin
		int         produced;
		int         sel;
		int         pick;
		bit         had;
		pte_class_t cls;
		logic [VA_W-1:0] va;
		logic [PA_W-1:0] root;

		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_START;
		virtual_address = '0;
		root_table_address = '0;
		entry_data = '0;
		walker_busy = 1'b0;
		walker_level = '0;
		walker_vpn = '0;
		walker_entry_addr = '0;
		fail_count = 0;
		mismatch_count = 0;
		results_seen = 0;
		burst_left = 0;
		idle_cycles = 0;
		produced = 0;

		// Directed rows: extremes, wrap, ignored words and every kind of entry.
		add_row(CMD_RESPONSE, '0, '0, '1, 1'b1, 1'b0, KIND_FINISH, '0, 1'b0);
		add_row(CMD_START, '0, '0, '0, 1'b1, 1'b1, KIND_REQUEST, '0, 1'b0);
		add_row(CMD_RESPONSE, '0, '0, '0, 1'b1, 1'b1, KIND_FINISH, '0, 1'b0);
		add_row(CMD_START, '1, '1, '0, 1'b1, 1'b1, KIND_REQUEST, 56'hFF7, 1'b0);
		add_row(CMD_START, '0, '0, '0, 1'b1, 1'b0, KIND_FINISH, '0, 1'b0);
		add_row(CMD_RESPONSE, '0, '0, 64'h3, 1'b1, 1'b1, KIND_FINISH, 56'hFF7, 1'b1);
		add_row(CMD_START, '1, '0, '0, 1'b1, 1'b1, KIND_REQUEST, 56'hFF8, 1'b0);
		add_row(CMD_RESPONSE, '0, '0, {10'h000, 44'hFFF_FFFF_FFFF, 10'h001}, 1'b0, 1'b0,
			KIND_FINISH, '0, 1'b0);
		add_row(CMD_RESPONSE, '0, '0, 64'hFFC0_0000_0000_0001, 1'b0, 1'b0, KIND_FINISH, '0,
			1'b0);
		add_row(CMD_RESPONSE, '0, '0, 64'h1, 1'b1, 1'b1, KIND_FINISH, '0, 1'b0);
		add_row(CMD_START, 39'h12_3456_789A, 56'h80_0000_0000_1000, '0, 1'b0, 1'b0,
			KIND_FINISH, '0, 1'b0);
		add_row(CMD_RESPONSE, '0, '0, 64'h5, 1'b0, 1'b0, KIND_FINISH, '0, 1'b0);
		add_row(CMD_START, 39'h7F_FFFF_F000, 56'h00_0000_1234_0000, '0, 1'b0, 1'b0,
			KIND_FINISH, '0, 1'b0);
		add_row(CMD_RESPONSE, '0, '0, 64'h9, 1'b0, 1'b0, KIND_FINISH, '0, 1'b0);
		add_row(CMD_START, '0, 56'hAB_CDEF_0123_4568, '1, 1'b0, 1'b0, KIND_FINISH, '0, 1'b0);
		add_row(CMD_RESPONSE, '1, '1, 64'hE, 1'b1, 1'b1, KIND_FINISH, '0, 1'b0);
		add_row(CMD_RESPONSE, '0, '0, 64'h1, 1'b1, 1'b0, KIND_FINISH, '0, 1'b0);
		add_row(CMD_START, 39'h40_2010_0000, 56'h1000, '0, 1'b0, 1'b0, KIND_FINISH, '0, 1'b0);
		add_row(CMD_RESPONSE, '0, '0, 64'h0000_1234_5678_9C01, 1'b0, 1'b0, KIND_FINISH, '0,
			1'b0);
		add_row(CMD_RESPONSE, '0, '0, '1, 1'b0, 1'b0, KIND_FINISH, '0, 1'b0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].cmd, directed_rows[i].va, directed_rows[i].root,
				directed_rows[i].pte, directed_rows[i].typed, directed_rows[i].has,
				directed_rows[i].res, had);

		// Random part: mostly complete walks, some broken sequences and noise.
		while (produced < RANDOM_WORDS) begin
			sel = $urandom_range(0, 99);
			if (sel < 85) begin
				if (walker_busy)
					offer(CMD_RESPONSE, '0, '0, make_entry(PTE_INVALID), produced);
				va = VA_W'({$urandom(), $urandom()});
				root = PA_W'({$urandom(), $urandom()});
				if ($urandom_range(0, 9) == 0)
					root = {PA_W{1'b1}} - PA_W'($urandom_range(0, 4095));
				offer(CMD_START, va, root, {$urandom(), $urandom()}, produced);
				for (int lvl = 0; lvl < LEVELS; lvl++) begin
					if ($urandom_range(0, 19) == 0)
						offer(CMD_START, VA_W'({$urandom(), $urandom()}),
							PA_W'({$urandom(), $urandom()}), '0, produced);
					pick = $urandom_range(0, 99);
					cls = (pick < 15) ? PTE_INVALID : (pick < 45) ? PTE_LEAF : PTE_POINTER;
					offer(CMD_RESPONSE, VA_W'({$urandom(), $urandom()}),
						PA_W'({$urandom(), $urandom()}), make_entry(cls), produced);
					if (cls != PTE_POINTER)
						break;
				end
				if ($urandom_range(0, 9) == 0)
					offer(CMD_RESPONSE, '0, '0, {$urandom(), $urandom()}, produced);
			end else begin
				offer(($urandom_range(0, 1) == 0) ? CMD_START : CMD_RESPONSE,
					VA_W'({$urandom(), $urandom()}), PA_W'({$urandom(), $urandom()}),
					{$urandom(), $urandom()}, produced);
			end
		end

		// Drain: wait for every expected word, then idle before the verdict.
		in_valid <= 1'b0;
		while (expected_walk_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_walk_words.size() == 0)
			$display("** sv39_page_table_walker_top: PASSED **");
		else
			$display("** sv39_page_table_walker_top: FAILED **");
		$finish;
	end

endmodule

>>> files.f
src/svptw_pkg.sv
src/svptw_front.sv
src/svptw_queue.sv
src/svptw_back.sv
src/sv39_page_table_walker_top.sv
test/tb.sv
